// ===== sv/aapc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Ring gauge arc pixel classifier: shared definitions
// Widths, register indexes, data structures and the arctangent table that
// the CORDIC cells use.
// ============================================================================
package aapc_pkg;

    localparam int MAX_RADIUS   = 127;
    localparam int ANGLE_BITS   = 16;
    localparam int PERCENT_FULL = 100;

    localparam int OFFSET_W  = 8;
    localparam int MAG_W     = 8;
    localparam int SQ_W      = 2 * MAG_W - 1;
    localparam int D2_W      = SQ_W + 1;
    localparam int CENTER_W  = 9;
    localparam int RADIUS_W  = 7;
    localparam int RADSQ_W   = 2 * RADIUS_W;
    localparam int SWEEP_W   = 7;
    localparam int COLOR_W   = 16;
    localparam int PIXEL_W   = 11;
    localparam int PROD_W    = ANGLE_BITS + SWEEP_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 2 * OFFSET_W;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PERCENT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_COLOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR    = 3'd6;

    // Coordinates carry COORD_FRAC fraction bits; angles are fractions of a
    // turn with ANG_FRAC fraction bits.
    localparam int CORDIC_STEPS = 48;
    localparam int SHIFT_W      = $clog2(CORDIC_STEPS);
    localparam int COORD_FRAC   = 48;
    localparam int COORD_W      = MAG_W + 2 + COORD_FRAC;
    localparam int ANG_FRAC     = 52;
    localparam int ANG_W        = ANG_FRAC + 2;

    localparam logic signed [ANG_W-1:0] EIGHTH_TURN  = ANG_W'(1) << (ANG_FRAC - 3);
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(1) << (ANG_FRAC - 2);
    localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(1) << (ANG_FRAC - 1);
    localparam logic signed [ANG_W-1:0] FULL_TURN    = ANG_W'(1) << ANG_FRAC;

    localparam real PI_REAL      = 3.14159265358979323846;
    localparam real TURN_PER_RAD = 1.0 / (2.0 * PI_REAL);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [ANG_W-1:0]   z;
    } vec_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] dx;
        logic signed [OFFSET_W-1:0] dy;
        logic [SQ_W-1:0]            sq_x;
        logic [SQ_W-1:0]            sq_y;
        logic                       zero_a;
        logic                       zero_b;
        logic                       diag;
        logic                       a_lt_b;
        logic                       v_neg;
        logic                       u_neg;
    } side_t;

    typedef struct packed {
        vec_t  vec;
        side_t side;
    } stage_t;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [RADIUS_W-1:0] outer_radius;
        logic [RADIUS_W-1:0] inner_radius;
        logic [SWEEP_W-1:0]  sweep_percent;
        logic [COLOR_W-1:0]  track_color;
        logic [COLOR_W-1:0]  fill_color;
    } cfg_t;

    typedef struct packed {
        logic                      draw;
        logic signed [PIXEL_W-1:0] pixel_x;
        logic signed [PIXEL_W-1:0] pixel_y;
        logic [COLOR_W-1:0]        color;
        logic                      is_fill;
    } res_t;

    // atan(2^-i) as a fraction of a turn, evaluated at elaboration.
    function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
        real r;
        r = $atan(2.0 ** (-i)) * TURN_PER_RAD * (2.0 ** ANG_FRAC);
        return ANG_W'(longint'(r));
    endfunction

endpackage

// ===== sv/annulus_arc_pixel_classifier.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Ring gauge arc pixel classifier
// Classifies a pixel offset against a ring of given radii and a filled arc
// that starts at 12 o'clock and runs clockwise.
// ============================================================================
// The block takes one pixel request per clock and returns one result per
// request, in order. A request passes an input stage, a chain of 48 CORDIC
// cells that resolve the angle, and three result stages before it enters a
// two-entry output buffer. The pipeline only halts while the output buffer
// is full. Registers are written through the cfg port and should only be
// changed while no request is in flight.
module annulus_arc_pixel_classifier (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [aapc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aapc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // offset_x [7:0], offset_y [15:8]
    input  logic [aapc_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_x [10:0], pixel_y [21:11], color [37:22], zero [39:38]
    output logic [aapc_pkg::M_TDATA_W-1:0]      m_tdata,
    // draw [0], is_fill [1]
    output logic [aapc_pkg::M_TUSER_W-1:0]      m_tuser
);
    import aapc_pkg::*;

    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [RADIUS_W-1:0] outer_radius_reg;
    logic [RADIUS_W-1:0] inner_radius_reg;
    logic [SWEEP_W-1:0]  sweep_percent_reg;
    logic [COLOR_W-1:0]  track_color_reg;
    logic [COLOR_W-1:0]  fill_color_reg;
    cfg_t                cfg;

    logic   adv;
    logic   chain_valid [CORDIC_STEPS+1];
    stage_t chain_data  [CORDIC_STEPS+1];
    logic   res_valid;
    res_t   res_data;
    res_t   out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            outer_radius_reg  <= '0;
            inner_radius_reg  <= '0;
            sweep_percent_reg <= '0;
            track_color_reg   <= '0;
            fill_color_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CENTER_X:      center_x_reg      <= cfg_wdata[CENTER_W-1:0];
                REG_CENTER_Y:      center_y_reg      <= cfg_wdata[CENTER_W-1:0];
                REG_OUTER_RADIUS:  outer_radius_reg  <= cfg_wdata[RADIUS_W-1:0];
                REG_INNER_RADIUS:  inner_radius_reg  <= cfg_wdata[RADIUS_W-1:0];
                REG_SWEEP_PERCENT: sweep_percent_reg <= cfg_wdata[SWEEP_W-1:0];
                REG_TRACK_COLOR:   track_color_reg   <= cfg_wdata[COLOR_W-1:0];
                REG_FILL_COLOR:    fill_color_reg    <= cfg_wdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.center_x      = center_x_reg;
        cfg.center_y      = center_y_reg;
        cfg.outer_radius  = outer_radius_reg;
        cfg.inner_radius  = inner_radius_reg;
        cfg.sweep_percent = sweep_percent_reg;
        cfg.track_color   = track_color_reg;
        cfg.fill_color    = fill_color_reg;
    end

    assign s_tready = adv;

    aapc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .offset_x  (s_tdata[OFFSET_W-1:0]),
        .offset_y  (s_tdata[2*OFFSET_W-1:OFFSET_W]),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        aapc_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .shift     (SHIFT_W'(i)),
            .atan_step (atan_turn(i)),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    aapc_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_data   (chain_data[CORDIC_STEPS]),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

    aapc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (adv && res_valid),
        .push_data (res_data),
        .space     (adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = M_TDATA_W'({out_res.color, out_res.pixel_y, out_res.pixel_x});
    assign m_tuser = {out_res.is_fill, out_res.draw};

endmodule

// ===== sv/aapc_prep.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Ring gauge arc pixel classifier: input stage
// Folds the offset into the first octant, squares the magnitudes and loads
// the starting vector of the CORDIC chain.
// ============================================================================
module aapc_prep (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic signed [aapc_pkg::OFFSET_W-1:0] offset_x,
    input  logic signed [aapc_pkg::OFFSET_W-1:0] offset_y,
    output logic                               out_valid,
    output aapc_pkg::stage_t                   out_data
);
    import aapc_pkg::*;

    logic             valid_reg;
    stage_t           data_reg;
    stage_t           data_next;
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
    logic [MAG_W-1:0] mag_max;
    logic [MAG_W-1:0] mag_min;

    always_comb begin
        mag_a = offset_x[OFFSET_W-1] ? MAG_W'(-offset_x) : MAG_W'(offset_x);
        mag_b = offset_y[OFFSET_W-1] ? MAG_W'(-offset_y) : MAG_W'(offset_y);
        mag_max = (mag_a < mag_b) ? mag_b : mag_a;
        mag_min = (mag_a < mag_b) ? mag_a : mag_b;

        data_next.side.dx     = offset_x;
        data_next.side.dy     = offset_y;
        data_next.side.sq_x   = SQ_W'(mag_a) * SQ_W'(mag_a);
        data_next.side.sq_y   = SQ_W'(mag_b) * SQ_W'(mag_b);
        data_next.side.zero_a = (mag_a == '0);
        data_next.side.zero_b = (mag_b == '0);
        data_next.side.diag   = (mag_a == mag_b);
        data_next.side.a_lt_b = (mag_a < mag_b);
        data_next.side.v_neg  = offset_x[OFFSET_W-1];
        data_next.side.u_neg  = (offset_y > 0);
        data_next.vec.x = COORD_W'({mag_max, COORD_FRAC'(0)});
        data_next.vec.y = COORD_W'({mag_min, COORD_FRAC'(0)});
        data_next.vec.z = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/aapc_cordic_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Ring gauge arc pixel classifier: CORDIC cell
// One vectoring micro-rotation, registered; the side information of the
// pixel travels along with the vector.
// ============================================================================
module aapc_cordic_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic [aapc_pkg::SHIFT_W-1:0]       shift,
    input  logic signed [aapc_pkg::ANG_W-1:0]  atan_step,
    input  logic                               in_valid,
    input  aapc_pkg::stage_t                   in_data,
    output logic                               out_valid,
    output aapc_pkg::stage_t                   out_data
);
    import aapc_pkg::*;

    logic                      valid_reg;
    stage_t                    data_reg;
    stage_t                    data_next;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;

    always_comb begin
        sx = in_data.vec.x >>> shift;
        sy = in_data.vec.y >>> shift;
        data_next.side = in_data.side;
        if (!in_data.vec.y[COORD_W-1]) begin
            data_next.vec.x = in_data.vec.x + sy;
            data_next.vec.y = in_data.vec.y - sx;
            data_next.vec.z = in_data.vec.z + atan_step;
        end else begin
            data_next.vec.x = in_data.vec.x - sy;
            data_next.vec.y = in_data.vec.y + sx;
            data_next.vec.z = in_data.vec.z - atan_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/aapc_finish.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Ring gauge arc pixel classifier: result stages
// Annulus test, angle assembly from the octant, sweep test and colour
// choice, over three register stages.
// ============================================================================
module aapc_finish (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  aapc_pkg::cfg_t   cfg,
    input  logic             in_valid,
    input  aapc_pkg::stage_t in_data,
    output logic             out_valid,
    output aapc_pkg::res_t   out_data
);
    import aapc_pkg::*;

    logic [2:0]                 valid_reg;

    logic                       a_draw_reg;
    logic signed [ANG_W-1:0]    a_phi_reg;
    logic                       a_v_neg_reg;
    logic                       a_u_neg_reg;
    logic signed [OFFSET_W-1:0] a_dx_reg;
    logic signed [OFFSET_W-1:0] a_dy_reg;

    logic                       b_draw_reg;
    logic [ANGLE_BITS-1:0]      b_code_reg;
    logic signed [OFFSET_W-1:0] b_dx_reg;
    logic signed [OFFSET_W-1:0] b_dy_reg;

    res_t                       res_reg;

    logic [D2_W-1:0]            d2;
    logic [RADSQ_W-1:0]         ro2;
    logic [RADSQ_W-1:0]         ri2;
    logic                       draw_next;
    logic signed [ANG_W-1:0]    phi_next;
    logic signed [ANG_W-1:0]    angle;
    logic [PROD_W-1:0]          scaled_code;
    logic [PROD_W-1:0]          sweep_limit;
    logic                       fill;
    res_t                       res_next;

    always_comb begin
        d2  = D2_W'(in_data.side.sq_x) + D2_W'(in_data.side.sq_y);
        ro2 = RADSQ_W'(cfg.outer_radius) * RADSQ_W'(cfg.outer_radius);
        ri2 = RADSQ_W'(cfg.inner_radius) * RADSQ_W'(cfg.inner_radius);
        draw_next = (d2 <= D2_W'(ro2)) && (d2 >= D2_W'(ri2));

        if (in_data.side.zero_a) begin
            phi_next = '0;
        end else if (in_data.side.zero_b) begin
            phi_next = QUARTER_TURN;
        end else if (in_data.side.diag) begin
            phi_next = EIGHTH_TURN;
        end else if (in_data.side.a_lt_b) begin
            phi_next = in_data.vec.z;
        end else begin
            phi_next = QUARTER_TURN - in_data.vec.z;
        end
    end

    always_comb begin
        case ({a_v_neg_reg, a_u_neg_reg})
            2'b00:   angle = a_phi_reg;
            2'b01:   angle = HALF_TURN - a_phi_reg;
            2'b11:   angle = HALF_TURN + a_phi_reg;
            default: angle = FULL_TURN - a_phi_reg;
        endcase
    end

    always_comb begin
        scaled_code = PROD_W'(b_code_reg) * PROD_W'(PERCENT_FULL);
        sweep_limit = {cfg.sweep_percent, ANGLE_BITS'(0)};
        fill = b_draw_reg && (scaled_code <= sweep_limit);

        res_next.draw    = b_draw_reg;
        res_next.is_fill = fill;
        res_next.color   = fill ? cfg.fill_color : (b_draw_reg ? cfg.track_color : '0);
        res_next.pixel_x = $signed({2'b00, cfg.center_x}) + PIXEL_W'(b_dx_reg);
        res_next.pixel_y = $signed({2'b00, cfg.center_y}) + PIXEL_W'(b_dy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
        if (adv) begin
            a_draw_reg  <= draw_next;
            a_phi_reg   <= phi_next;
            a_v_neg_reg <= in_data.side.v_neg;
            a_u_neg_reg <= in_data.side.u_neg;
            a_dx_reg    <= in_data.side.dx;
            a_dy_reg    <= in_data.side.dy;

            b_draw_reg  <= a_draw_reg;
            b_code_reg  <= angle[ANG_FRAC-1 -: ANGLE_BITS];
            b_dx_reg    <= a_dx_reg;
            b_dy_reg    <= a_dy_reg;

            res_reg     <= res_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = res_reg;

endmodule

// ===== sv/aapc_out_buf.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Ring gauge arc pixel classifier: output buffer
// Two-entry buffer that decouples the result channel from the pipeline, so
// that the pipeline stall is taken from a register.
// ============================================================================
module aapc_out_buf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  aapc_pkg::res_t push_data,
    output logic           space,
    output logic           out_valid,
    input  logic           out_ready,
    output aapc_pkg::res_t out_data
);
    import aapc_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    res_t       head_reg;
    res_t       tail_reg;
    logic       pop;

    assign pop = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        if ((count_reg == 2'd0 && push) || (count_reg == 2'd1 && push && pop)) begin
            head_reg <= push_data;
        end else if (count_reg == 2'd2 && pop) begin
            head_reg <= tail_reg;
        end
        if (count_reg == 2'd1 && push && !pop) begin
            tail_reg <= push_data;
        end
    end

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;

endmodule

// ===== sv/aapc_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Ring gauge arc pixel classifier: port checker
// Watches the ports of the top level and is bound to it.
// ============================================================================
module aapc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [aapc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [aapc_pkg::M_TUSER_W-1:0] m_tuser
);
    import aapc_pkg::*;

    // A stalled result must hold still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A pixel outside the ring carries neither colour nor fill flag.
    a_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> !m_tuser[1] && m_tdata[37:22] == '0)
        else $error("undrawn pixel carries colour");

    // Only drawn pixels can be filled.
    a_fill_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("fill without draw");

    // The input side only closes when a result has been held back.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input closed without output back-pressure");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

endmodule

bind annulus_arc_pixel_classifier aapc_checker u_aapc_checker (.*);
